// ===== rtl/sifq_pkg.sv =====
// Shared package of the sorted insert queue: depth, widths, operation and status codes,
// and the command struct between controller and datapath. No dependencies.
`default_nettype none

package sifq_pkg;

  // Entry storage depth and derived widths
  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int KEY_W       = 32;
  localparam int TAG_W       = 16;
  localparam int OP_W        = 2;
  localparam int STAT_W      = 2;
  localparam int OCC_W       = 5;

  // Operation codes
  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_SORTED = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the accepted transaction
    logic evaluate;  // build the insert position mask
    logic commit;    // update the cells and load the result
  } sifq_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/sifq_in_if.sv =====
// Input channel interface of the sorted insert queue: valid, ready and the operation payload.
// Depends on sifq_pkg for field widths.
`default_nettype none

interface sifq_in_if
  import sifq_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic signed [KEY_W-1:0] item_key;
  logic [TAG_W-1:0]        item_tag;

  modport source (output valid, output operation, output item_key, output item_tag,
                  input ready);
  modport sink   (input valid, input operation, input item_key, input item_tag,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/sifq_out_if.sv =====
// Result channel interface of the sorted insert queue: valid, ready and the result payload.
// Depends on sifq_pkg for field widths.
`default_nettype none

interface sifq_out_if
  import sifq_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic                    head_valid;
  logic signed [KEY_W-1:0] head_key;
  logic [TAG_W-1:0]        head_tag;
  logic [STAT_W-1:0]       status;
  logic [OCC_W-1:0]        occupancy;

  modport source (output valid, output head_valid, output head_key, output head_tag,
                  output status, output occupancy, input ready);
  modport sink   (input valid, input head_valid, input head_key, input head_tag,
                  input status, input occupancy, output ready);
endinterface

`default_nettype wire

// ===== rtl/sifq_ctrl.sv =====
// Controller of the sorted insert queue: sequences capture, evaluate and commit, and owns
// the result valid flag. Depends on sifq_pkg.
`default_nettype none

module sifq_ctrl
  import sifq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output sifq_cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_COMMIT} state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   commit_go;

  // Accept a transaction only between operations
  assign in_ready  = (state_r == S_IDLE);
  assign commit_go = (state_r == S_COMMIT) && (!out_valid_r || out_ready);

  assign cmd.capture  = in_valid && in_ready;
  assign cmd.evaluate = (state_r == S_EVAL);
  assign cmd.commit   = commit_go;
  assign out_valid    = out_valid_r;

  // Advance state and hold the result valid flag until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_EVAL;
        end
        S_EVAL: begin
          state_r <= S_COMMIT;
        end
        S_COMMIT: begin
          if (commit_go) state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (commit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sifq_dpath.sv =====
// Datapath of the sorted insert queue: a row of key/tag cells with per-cell compare,
// the insert position mask, the entry count and the result registers. Depends on sifq_pkg.
`default_nettype none

module sifq_dpath
  import sifq_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire sifq_cmd_t               cmd,
  input  wire logic [OP_W-1:0]         in_operation,
  input  wire logic signed [KEY_W-1:0] in_item_key,
  input  wire logic [TAG_W-1:0]        in_item_tag,
  output logic                         out_head_valid,
  output logic signed [KEY_W-1:0]      out_head_key,
  output logic [TAG_W-1:0]             out_head_tag,
  output logic [STAT_W-1:0]            out_status,
  output logic [OCC_W-1:0]             out_occupancy
);

  // Captured transaction
  logic [OP_W-1:0]         op_r;
  logic signed [KEY_W-1:0] key_r;
  logic [TAG_W-1:0]        tag_r;

  // Cell row, head at index 0
  logic signed [KEY_W-1:0] cell_key_r [QUEUE_DEPTH];
  logic [TAG_W-1:0]        cell_tag_r [QUEUE_DEPTH];
  logic [CNT_W-1:0]        count_r;

  // Mask of cells at or after the insert position
  logic [QUEUE_DEPTH-1:0]  mask_r;
  logic [QUEUE_DEPTH-1:0]  mask_nxt;
  logic [QUEUE_DEPTH-1:0]  hit;

  logic                    is_full;
  logic                    is_empty;
  logic                    do_insert;
  logic                    do_remove;
  logic [CNT_W-1:0]        count_nxt;
  logic [CNT_W+OCC_W-1:0]  occ_ext;

  assign is_full   = (count_r == CNT_W'(QUEUE_DEPTH));
  assign is_empty  = (count_r == '0);
  assign do_insert = ((op_r == OP_APPEND) || (op_r == OP_SORTED)) && !is_full;
  assign do_remove = (op_r == OP_REMOVE) && !is_empty;

  // Compare every stored cell against the new key; unused cells always hit
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (CNT_W'(i) >= count_r) begin
        hit[i] = 1'b1;
      end else begin
        hit[i] = (op_r == OP_SORTED) && (cell_key_r[i] >= key_r);
      end
    end
    mask_nxt[0] = hit[0];
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      mask_nxt[i] = mask_nxt[i-1] | hit[i];
    end
  end

  // Next entry count
  always_comb begin
    count_nxt = count_r;
    if (do_insert) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_remove) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign occ_ext = {{OCC_W{1'b0}}, count_nxt};

  // Latch transaction and position mask
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_operation;
      key_r <= in_item_key;
      tag_r <= in_item_tag;
    end
    if (cmd.evaluate) begin
      mask_r <= mask_nxt;
    end
  end

  // Shift the cell row open for an insert or closed for a remove
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (do_insert) begin
          if (mask_r[i] && ((i == 0) || !mask_r[(i == 0) ? 0 : i-1])) begin
            cell_key_r[i] <= key_r;
            cell_tag_r[i] <= tag_r;
          end else if (mask_r[i]) begin
            cell_key_r[i] <= cell_key_r[(i == 0) ? 0 : i-1];
            cell_tag_r[i] <= cell_tag_r[(i == 0) ? 0 : i-1];
          end
        end else if (do_remove && (i < QUEUE_DEPTH - 1)) begin
          cell_key_r[i] <= cell_key_r[(i < QUEUE_DEPTH - 1) ? i+1 : i];
          cell_tag_r[i] <= cell_tag_r[(i < QUEUE_DEPTH - 1) ? i+1 : i];
        end
      end
    end
  end

  // Hold the entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_head_valid <= do_remove;
      out_head_key   <= do_remove ? cell_key_r[0] : '0;
      out_head_tag   <= do_remove ? cell_tag_r[0] : '0;
      out_occupancy  <= occ_ext[OCC_W-1:0];
      priority if (((op_r == OP_APPEND) || (op_r == OP_SORTED)) && is_full) begin
        out_status <= ST_FULL;
      end else if ((op_r == OP_REMOVE) && is_empty) begin
        out_status <= ST_EMPTY;
      end else begin
        out_status <= ST_DONE;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_insert_fifo_queue_unit.sv =====
// Sorted insert queue: bounded list of signed keys with tags, head at the front.
// Instantiates sifq_ctrl and sifq_dpath; depends on sifq_pkg, sifq_in_if and sifq_out_if.
//
// Usage:
//   in_chan carries one operation per transaction: append at tail, sorted insert
//   (before the first stored key greater than or equal to the new one) or remove head.
//   out_chan returns exactly one result per operation: removed entry, status and the
//   occupancy after the operation.
// Sequence:
//   A transaction passes through capture, an evaluate step in which every cell compares its
//   key against the new key in parallel and the insert mask is registered, and a commit
//   step that shifts the cell row and loads the result register. The next transaction
//   is taken in the cycle after commit; no new operation is accepted before then.
// Stalls:
//   The result register holds while out_chan.ready is low; a new transaction may be
//   taken and evaluated meanwhile, and its commit waits until the result is taken.
// Reset:
//   rst_n (synchronous, active low) empties the queue and drops any pending result.
//   Cell contents are not cleared; only occupied cells are ever compared or returned.
`default_nettype none

module sorted_insert_fifo_queue_unit
  import sifq_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  sifq_in_if.sink    in_chan,
  sifq_out_if.source out_chan
);

  sifq_cmd_t cmd;

  sifq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  sifq_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_operation   (in_chan.operation),
    .in_item_key    (in_chan.item_key),
    .in_item_tag    (in_chan.item_tag),
    .out_head_valid (out_chan.head_valid),
    .out_head_key   (out_chan.head_key),
    .out_head_tag   (out_chan.head_tag),
    .out_status     (out_chan.status),
    .out_occupancy  (out_chan.occupancy)
  );

endmodule

`default_nettype wire
